@@ design/prqc_pkg.sv @@
// Shared types and constants for the port range queue classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package prqc_pkg;

  localparam int unsigned NumClassesDef = 16;

  localparam logic OpClassify = 1'b0;
  localparam logic OpWrite    = 1'b1;

  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [15:0] MinIpLen  = 16'd34;
  localparam logic [15:0] MinTcpLen = 16'd54;
  localparam logic [15:0] MinUdpLen = 16'd42;

  localparam int unsigned PortW      = 16;
  localparam int unsigned DividendW  = 32;
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned DivIters   = DividendW / BitsPerStep;
  localparam int unsigned DivCntW    = $clog2(DivIters);

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    VerdictPass   = 2'd0,
    VerdictDrop   = 2'd1,
    VerdictUnspec = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkDiv  = 3'b010,
    BkOut  = 3'b100
  } back_state_e;

  // One classified request handed from the front to the back end.
  typedef struct packed {
    verdict_e              verdict;
    logic                  need_div;
    logic [DividendW-1:0]  dividend;
    logic [PortW-1:0]      divisor;
    logic [PortW-1:0]      base;
    logic [3:0]            prio;
  } job_t;

endpackage

`default_nettype wire

@@ design/prqc_front.sv @@
// Front end: class table, request intake, header checks and first-match search.
// Depends on prqc_pkg; feeds prqc_fifo.
`default_nettype none

module prqc_front #(
  parameter int unsigned NUM_CLASSES = prqc_pkg::NumClassesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            op_i,
  input  wire logic [15:0]     frame_length_i,
  input  wire logic [7:0]      ip_protocol_i,
  input  wire logic [15:0]     dest_port_i,
  input  wire logic [3:0]      class_index_i,
  input  wire logic [15:0]     entry_port_start_i,
  input  wire logic [15:0]     entry_port_count_i,
  input  wire logic [15:0]     entry_queue_base_i,
  output logic                 push_o,
  output prqc_pkg::job_t       job_o,
  input  wire logic            full_i
);
  import prqc_pkg::*;

  localparam int unsigned IdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [PortW-1:0] start_q [NUM_CLASSES];
  logic [PortW-1:0] count_q [NUM_CLASSES];
  logic [PortW-1:0] base_q  [NUM_CLASSES];

  logic                   s1_vld_q;
  logic [NUM_CLASSES-1:0] s1_hit_q;
  logic [NUM_CLASSES-1:0] hit_d;
  logic [PortW-1:0]       s1_port_q;
  verdict_e               s1_verdict_q;
  verdict_e               verdict_d;

  logic            accept;
  logic [IdxW-1:0] sel;
  logic            found;
  logic [PortW-1:0] sel_start;

  // One request in flight in the search stage at a time; this also keeps a
  // table write from landing between the compare and the entry read.
  assign in_stall_o = s1_vld_q;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_CLASSES); i++) begin
        start_q[i] <= '0;
        count_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else if (accept && op_i == OpWrite) begin
      for (int i = 0; i < int'(NUM_CLASSES); i++) begin
        if (32'(class_index_i) == 32'(i)) begin
          start_q[i] <= entry_port_start_i;
          count_q[i] <= entry_port_count_i;
          base_q[i]  <= entry_queue_base_i;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < int'(NUM_CLASSES); i++) begin
      hit_d[i] = (count_q[i] != '0) &&
                 ({1'b0, dest_port_i} < ({1'b0, start_q[i]} + {1'b0, count_q[i]}));
    end
  end

  always_comb begin
    verdict_d = VerdictPass;
    if (frame_length_i < MinIpLen) begin
      verdict_d = VerdictDrop;
    end else if (ip_protocol_i != ProtoTcp && ip_protocol_i != ProtoUdp) begin
      verdict_d = VerdictUnspec;
    end else if ((ip_protocol_i == ProtoTcp && frame_length_i < MinTcpLen) ||
                 (ip_protocol_i == ProtoUdp && frame_length_i < MinUdpLen)) begin
      verdict_d = VerdictDrop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept && op_i == OpClassify) begin
      s1_vld_q <= 1'b1;
    end else if (push_o) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_i == OpClassify) begin
      s1_hit_q     <= hit_d;
      s1_port_q    <= dest_port_i;
      s1_verdict_q <= verdict_d;
    end
  end

  // lowest matching class wins
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = int'(NUM_CLASSES) - 1; i >= 0; i--) begin
      if (s1_hit_q[i]) begin
        sel   = IdxW'(i);
        found = 1'b1;
      end
    end
  end

  assign sel_start = start_q[sel];

  assign push_o = s1_vld_q && !full_i;

  always_comb begin
    job_o.verdict  = s1_verdict_q;
    job_o.need_div = (s1_verdict_q == VerdictPass) && found;
    job_o.dividend = DividendW'(s1_port_q) - DividendW'(sel_start);
    job_o.divisor  = count_q[sel];
    job_o.base     = base_q[sel];
    job_o.prio     = 4'(sel);
  end

endmodule

`default_nettype wire

@@ design/prqc_fifo.sv @@
// Short request queue between the front and the back end.
// Depends on prqc_pkg for the job type and depth.
`default_nettype none

module prqc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire prqc_pkg::job_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output prqc_pkg::job_t      data_o,
  output logic                empty_o
);
  import prqc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/prqc_back.sv @@
// Back end: serial remainder (two bits per cycle), queue pick and result register.
// Depends on prqc_pkg; drains prqc_fifo.
`default_nettype none

module prqc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire prqc_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          verdict_o,
  output logic                marked_o,
  output logic [3:0]          priority_res_o,
  output logic [15:0]         queue_sel_o
);
  import prqc_pkg::*;

  back_state_e          state_q, state_d;
  logic [DivCntW-1:0]   cnt_q;
  logic [DividendW-1:0] dvd_q;
  logic [PortW-1:0]     dvs_q, base_q, rem_q, rem_d;
  logic [3:0]           prio_q;
  verdict_e             verdict_q;
  logic                 need_div_q;

  logic                 out_vld_q;
  logic [1:0]           res_verdict_q;
  logic                 res_marked_q;
  logic [3:0]           res_prio_q;
  logic [15:0]          res_qmap_q;

  logic [PortW:0]       t1, t2, queue;
  logic [PortW-1:0]     r1;
  logic                 load_out;

  // restoring steps, remainder always stays below the divisor
  always_comb begin
    t1    = {rem_q, dvd_q[DividendW-1]};
    r1    = (t1 >= {1'b0, dvs_q}) ? PortW'(t1 - {1'b0, dvs_q}) : t1[PortW-1:0];
    t2    = {r1, dvd_q[DividendW-2]};
    rem_d = (t2 >= {1'b0, dvs_q}) ? PortW'(t2 - {1'b0, dvs_q}) : t2[PortW-1:0];
  end

  assign queue    = {1'b0, base_q} + {1'b0, rem_q};
  assign pop_o    = (state_q == BkIdle) && !empty_i;
  assign load_out = (state_q == BkOut) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: if (!empty_i) state_d = job_i.need_div ? BkDiv : BkOut;
      BkDiv:  if (cnt_q == DivCntW'(DivIters - 1)) state_d = BkOut;
      BkOut:  if (load_out) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvd_q      <= job_i.dividend;
      dvs_q      <= job_i.divisor;
      base_q     <= job_i.base;
      prio_q     <= job_i.prio;
      verdict_q  <= job_i.verdict;
      need_div_q <= job_i.need_div;
      rem_q      <= '0;
      cnt_q      <= '0;
    end else if (state_q == BkDiv) begin
      dvd_q <= dvd_q << BitsPerStep;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_verdict_q <= verdict_q;
      if (need_div_q && queue != '0) begin
        res_marked_q <= 1'b1;
        res_prio_q   <= prio_q;
        res_qmap_q   <= queue[PortW-1:0] + 16'd1;
      end else begin
        res_marked_q <= 1'b0;
        res_prio_q   <= '0;
        res_qmap_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign verdict_o      = res_verdict_q;
  assign marked_o       = res_marked_q;
  assign priority_res_o = res_prio_q;
  assign queue_sel_o    = res_qmap_q;

endmodule

`default_nettype wire

@@ design/port_range_queue_classifier.sv @@
// Top level of the port range queue classifier: front, request queue, back end.
// Depends on prqc_pkg, prqc_front, prqc_fifo and prqc_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid_i/in_stall_o   | op, frame_length, ip_protocol, dest_port,
//           |                         | class_index, entry_port_start/count/base
//   out     | out_valid_o/out_stall_i | verdict, marked, priority_res, queue_sel
//
// The front takes a new classify request only after the previous one has been pushed
// into the queue. A matched request then runs through the back end's remainder unit
// (32-bit dividend, 2 bits per cycle) before its result is registered.
// Reset clears the class table and all valid state at once.
// A 2-entry queue lets the front keep taking requests while the back end or
// a stalled output is busy.
`default_nettype none

module port_range_queue_classifier #(
  parameter int unsigned NUM_CLASSES = prqc_pkg::NumClassesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [15:0] frame_length_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [15:0] dest_port_i,
  input  wire logic [3:0]  class_index_i,
  input  wire logic [15:0] entry_port_start_i,
  input  wire logic [15:0] entry_port_count_i,
  input  wire logic [15:0] entry_queue_base_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o,
  output logic             marked_o,
  output logic [3:0]       priority_res_o,
  output logic [15:0]      queue_sel_o
);
  import prqc_pkg::*;

  job_t push_job, pop_job;
  logic push, pop, full, empty;

  prqc_front #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .frame_length_i    (frame_length_i),
    .ip_protocol_i     (ip_protocol_i),
    .dest_port_i       (dest_port_i),
    .class_index_i     (class_index_i),
    .entry_port_start_i(entry_port_start_i),
    .entry_port_count_i(entry_port_count_i),
    .entry_queue_base_i(entry_queue_base_i),
    .push_o            (push),
    .job_o             (push_job),
    .full_i            (full)
  );

  prqc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pop_job),
    .empty_o(empty)
  );

  prqc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o),
    .marked_o      (marked_o),
    .priority_res_o(priority_res_o),
    .queue_sel_o   (queue_sel_o)
  );

endmodule

`default_nettype wire
